// File: rtl/tile_screen_controller_unit_defines.svh
// assertion macros shared by the tile screen controller rtl
`ifndef TILE_SCREEN_CONTROLLER_UNIT_DEFINES_SVH
`define TILE_SCREEN_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define TSC_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TSC_ASSERT_HOLD(lbl, cond, msg)
`define TSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/tsc_pkg.sv
package tsc_pkg;

  // bus map
  localparam logic [15:0] BUFFER_BASE    = 16'h0000;
  localparam logic [15:0] MODE_ADDRESS   = 16'h0100;
  localparam logic [15:0] COLOUR_ADDRESS = 16'h0101;
  localparam int          BUFFER_WORDS   = 256;
  localparam int          CELL_AW        = $clog2(BUFFER_WORDS);
  localparam logic [16:0] WINDOW_SPAN    = 17'h00100;

  // mode register values and clear request bit
  localparam logic [31:0] MODE_CHAR  = 32'd0;
  localparam logic [31:0] MODE_NIB   = 32'd1;
  localparam logic [31:0] MODE_BIT   = 32'd2;
  localparam int          CLEAR_BIT  = 15;

  // request type on the input tuser
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // command kinds on the output tuser
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_GLYPH = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // rectangle sides
  localparam logic [3:0] SIZE_CELL = 4'd8;
  localparam logic [3:0] SIZE_NIB  = 4'd4;
  localparam logic [3:0] SIZE_BIT  = 4'd2;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // last command index per job
  localparam logic [3:0] LAST_SINGLE = 4'd0;
  localparam logic [3:0] LAST_NIB    = 4'd3;
  localparam logic [3:0] LAST_BIT    = 4'd15;

  // work pending after an accepted transaction
  typedef enum logic [2:0] {
    JOB_READ,
    JOB_CHAR,
    JOB_NIB,
    JOB_BIT,
    JOB_CLEAR
  } job_t;

  // cell buffer access, one port
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [CELL_AW-1:0] addr;
    logic [31:0]        wdata;
  } mem_req_t;

endpackage

// File: rtl/tsc_cell_mem.sv
module tsc_cell_mem
  import tsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0]             mem [BUFFER_WORDS];
  logic [BUFFER_WORDS-1:0] valid_r;
  logic [31:0]             rd_data_r;

  // storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // per-entry written flags, an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.addr] ? mem[req.addr] : 32'd0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/tile_screen_controller_unit.sv
// channel | dir | tdata                      | tuser     | tlast
// in_     | in  | address, write_data        | req_type  | -
// out_    | out | draw command fields        | cmd_kind  | last of access
//
// one transaction is accepted at a time; in_tready is high while idle.
// results leave one per cycle through the output register while out_tready
// allows; a read, glyph or clear gives one result, 4-bit mode four and
// 1-bit mode sixteen; writes that cause no result leave the unit idle.
// a read takes the cell buffer's registered read before its response.
// out_tready low holds the output register and the command sequencer.
// reset is synchronous; the cell buffer reads as zero until each entry is written.
`include "tile_screen_controller_unit_defines.svh"

module tile_screen_controller_unit
  import tsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // address[15:0], write_data[47:16]
  input  logic [0:0]             in_tuser,   // req_type[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // rect_x[6:0], rect_y[13:7], rect_size[17:14],
                                             // fill_colour[21:18], glyph_code[29:22],
                                             // glyph_colour[33:30], read_data[65:34],
                                             // read_hit[66], zero[71:67]
  output logic [1:0]             out_tuser,  // cmd_kind[1:0]
  output logic                   out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic [31:0]          val_r, val_nxt;
  logic [CELL_AW-1:0]   local_r, local_nxt;
  logic                 hit_r, hit_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [31:0]          mode_r, mode_nxt;
  logic [31:0]          colour_r, colour_nxt;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [1:0]           out_tuser_r;
  logic                 out_tlast_r;

  logic                 in_acc;
  logic                 in_req;
  logic [15:0]          in_addr;
  logic [31:0]          in_wdata;
  logic [15:0]          addr_off;
  logic                 in_win;
  logic                 launch;
  mem_req_t             mem_req;
  logic [31:0]          mem_rdata;

  logic                 out_load;
  logic [3:0]           last_idx;
  logic                 emit_last;
  logic [1:0]           e_kind;
  logic [6:0]           e_x;
  logic [6:0]           e_y;
  logic [3:0]           e_size;
  logic [3:0]           e_fill;
  logic [7:0]           e_code;
  logic [3:0]           e_fg;
  logic [31:0]          e_rdata;
  logic                 e_hit;

  // input unpacking and window decode
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_req    = in_tuser[0];
  assign in_addr   = in_tdata[15:0];
  assign in_wdata  = in_tdata[47:16];
  assign addr_off  = in_addr - BUFFER_BASE;
  assign in_win    = ({1'b0, in_addr} >= {1'b0, BUFFER_BASE})
                  && ({1'b0, in_addr} < ({1'b0, BUFFER_BASE} + WINDOW_SPAN));

  // transaction decode: buffer access, register writes, job setup
  always_comb begin
    launch     = 1'b0;
    job_nxt    = job_r;
    val_nxt    = val_r;
    local_nxt  = local_r;
    hit_nxt    = hit_r;
    mode_nxt   = mode_r;
    colour_nxt = colour_r;
    mem_req    = '{wr_en: 1'b0, rd_en: 1'b0, addr: addr_off[CELL_AW-1:0],
                   wdata: in_wdata ^ colour_r};
    if (in_acc) begin
      local_nxt = addr_off[CELL_AW-1:0];
      priority if (in_req == REQ_READ) begin
        launch         = 1'b1;
        job_nxt        = JOB_READ;
        hit_nxt        = in_win;
        mem_req.rd_en  = in_win;
      end else if (in_win) begin
        mem_req.wr_en = 1'b1;
        val_nxt       = in_wdata ^ colour_r;
        priority if (mode_r == MODE_CHAR) begin
          launch  = 1'b1;
          job_nxt = JOB_CHAR;
        end else if (mode_r == MODE_NIB) begin
          launch  = 1'b1;
          job_nxt = JOB_NIB;
        end else if (mode_r == MODE_BIT) begin
          launch  = 1'b1;
          job_nxt = JOB_BIT;
        end else begin
          launch  = 1'b0;
        end
      end else if (in_addr == MODE_ADDRESS) begin
        mode_nxt            = in_wdata;
        mode_nxt[CLEAR_BIT] = 1'b0;
        val_nxt             = colour_r;
        if (in_wdata[CLEAR_BIT]) begin
          launch  = 1'b1;
          job_nxt = JOB_CLEAR;
        end
      end else if (in_addr == COLOUR_ADDRESS) begin
        colour_nxt = in_wdata;
      end else begin
        launch = 1'b0;
      end
    end
  end

  tsc_cell_mem u_cell_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  // command sequencer
  always_comb begin
    unique case (job_r)
      JOB_NIB: last_idx = LAST_NIB;
      JOB_BIT: last_idx = LAST_BIT;
      default: last_idx = LAST_SINGLE;
    endcase
  end

  assign out_load  = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);
  assign emit_last = (cnt_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = 4'd0;
        if (launch) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // fields of the current command; cell origin is local column and row times 8
  always_comb begin
    e_kind  = KIND_READ;
    e_x     = 7'd0;
    e_y     = 7'd0;
    e_size  = 4'd0;
    e_fill  = 4'd0;
    e_code  = 8'd0;
    e_fg    = 4'd0;
    e_rdata = 32'd0;
    e_hit   = 1'b0;
    unique case (job_r)
      JOB_READ: begin
        e_rdata = hit_r ? mem_rdata : 32'd0;
        e_hit   = hit_r;
      end
      JOB_CHAR: begin
        e_kind = KIND_GLYPH;
        e_x    = {local_r[3:0], 3'b000};
        e_y    = {local_r[7:4], 3'b000};
        e_size = SIZE_CELL;
        e_fill = val_r[15:12];
        e_code = val_r[7:0];
        e_fg   = val_r[11:8];
      end
      JOB_NIB: begin
        e_kind = KIND_FILL;
        e_x    = {local_r[3:0], cnt_r[0], 2'b00};
        e_y    = {local_r[7:4], cnt_r[1], 2'b00};
        e_size = SIZE_NIB;
        unique case (cnt_r[1:0])
          2'd0: e_fill = val_r[3:0];
          2'd1: e_fill = val_r[7:4];
          2'd2: e_fill = val_r[11:8];
          2'd3: e_fill = val_r[15:12];
        endcase
      end
      JOB_BIT: begin
        e_kind = KIND_FILL;
        e_x    = {local_r[3:0], cnt_r[1:0], 1'b0};
        e_y    = {local_r[7:4], cnt_r[3:2], 1'b0};
        e_size = SIZE_BIT;
        e_fill = val_r[cnt_r] ? 4'hF : 4'h0;
      end
      JOB_CLEAR: begin
        e_kind = KIND_CLEAR;
        e_fill = val_r[15:12];
      end
      default: begin
        e_kind = KIND_READ;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= 4'd0;
      mode_r       <= 32'd0;
      colour_r     <= 32'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      mode_r       <= mode_nxt;
      colour_r     <= colour_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    val_r   <= val_nxt;
    local_r <= local_nxt;
    hit_r   <= hit_nxt;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {5'd0, e_hit, e_rdata, e_fg, e_code, e_fill, e_size, e_y, e_x};
      out_tuser_r <= e_kind;
      out_tlast_r <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // checks
  `TSC_ASSERT_NEXT(a_last_ends_job, out_load && emit_last, state_r == S_IDLE,
                   "sequencer still busy after last command")
  `TSC_ASSERT_IMPL(a_cnt_in_range, state_r == S_EMIT, cnt_r <= last_idx,
                   "command index past end of job")
  `TSC_ASSERT_NEXT(a_read_goes_emit, mem_req.rd_en, state_r == S_EMIT,
                   "buffer read issued without a response pending")
  `TSC_ASSERT_IMPL(a_single_is_last,
                   out_tvalid && (out_tuser != KIND_FILL), out_tlast,
                   "single-command access without tlast")
  `TSC_ASSERT_IMPL(a_hit_only_read, out_tvalid && out_tdata[66], out_tuser == KIND_READ,
                   "read hit flag on a draw command")

endmodule
